// ===== src/line_intersect_closest_point_assert.svh =====
// Assertion macros for the line geometry block.
`ifndef LINE_INTERSECT_CLOSEST_POINT_ASSERT_SVH
`define LINE_INTERSECT_CLOSEST_POINT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LIC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/lic_pkg.sv =====
// Shared types, constants and helpers for the line geometry pipeline.
package lic_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int XW        = DW + 1;
	localparam int DIV_STEPS = XW;
	localparam int TOL_W     = 16;

	localparam logic signed [DW-1:0] ONE_Q   = DW'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [1:0] {
		REL_POINT      = 2'd0,
		REL_PARALLEL   = 2'd1,
		REL_COINCIDENT = 2'd2
	} rel_t;

	typedef struct packed {
		logic signed [DW-1:0] v;
		logic                 o;
	} sat_t;

	typedef struct packed {
		logic                 valid;
		logic                 kind;
		logic                 v1;
		logic                 v2;
		logic                 par;
		logic                 gen0;
		logic                 gen1;
		logic                 aff;
		rel_t                 rel;
		logic                 ovf;
		logic signed [DW-1:0] px;
		logic signed [DW-1:0] py;
		logic signed [DW-1:0] rx;
		logic signed [DW-1:0] ry;
		logic signed [DW-1:0] a1;
		logic signed [DW-1:0] a2;
		logic signed [DW-1:0] c1;
		logic signed [DW-1:0] c2;
		logic signed [DW-1:0] pa;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
	} item_t;

	function automatic sat_t neg_sat(input logic signed [DW-1:0] v);
		sat_t r;
		if (v == MIN_VAL) begin
			r.v = MAX_VAL;
			r.o = 1'b1;
		end else begin
			r.v = -v;
			r.o = 1'b0;
		end
		return r;
	endfunction

	function automatic logic within_tol(input logic signed [XW-1:0] d,
		input logic [TOL_W-1:0] tol);
		logic [XW-1:0] mag;
		mag = d[XW-1] ? XW'(-d) : XW'(d);
		return mag <= XW'(tol);
	endfunction

endpackage

// ===== src/line_intersect_closest_point.sv =====
// Path from an accepted transaction to its result: input register, three 35-stage dividers,
// three 2-stage multiply units, output register.
// Throughput: one transaction per cycle; the whole pipeline holds while the output is stalled.
// The depth is set by the one-bit-per-stage dividers, which do not limit the rate.
// Reset clears all valid bits and sets tolerance to 1; payload registers are not reset.
module line_intersect_closest_point (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [lic_pkg::TOL_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic signed [lic_pkg::DW-1:0] p_x,
	input  logic signed [lic_pkg::DW-1:0] p_y,
	input  logic signed [lic_pkg::DW-1:0] q_x,
	input  logic signed [lic_pkg::DW-1:0] q_y,
	input  logic signed [lic_pkg::DW-1:0] r_x,
	input  logic signed [lic_pkg::DW-1:0] r_y,
	input  logic signed [lic_pkg::DW-1:0] s_x,
	input  logic signed [lic_pkg::DW-1:0] s_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [lic_pkg::DW-1:0] out_x,
	output logic signed [lic_pkg::DW-1:0] out_y,
	output logic [1:0]                    relation,
	output logic                          overflow
);
	localparam int DW = lic_pkg::DW;
	localparam int XW = lic_pkg::XW;

	logic                    en;
	logic [lic_pkg::TOL_W-1:0] tol_q;

	logic                    valid_s1, kind_s1;
	logic signed [DW-1:0]    px_s1, py_s1, qx_s1, qy_s1, rx_s1, ry_s1, sx_s1, sy_s1;

	logic signed [XW-1:0]    dx1, dx2, num1, num2;
	lic_pkg::item_t          ta_in, ta, tb_in, tb, tc_in, tc, td_in, td, te_in, te, tf_in, tf;
	logic signed [DW-1:0]    a1q, a2q, c1r, c2r, mq, pcr, xq, yr;
	logic                    oa1, oa2, oc1, oc2, om, opc, ox, oy;
	logic signed [DW-1:0]    c1_a, c1_y, c2_a, c2_y;
	logic signed [XW-1:0]    dnum_m, dden_m, dnum_x, dden_x;
	logic signed [DW-1:0]    ya, yc;
	lic_pkg::sat_t           ns_m, nc1, nc2;

	logic                    ov_q, rel_o, ovf_o;
	logic [1:0]              rel_q;
	logic                    ovf_q;
	logic signed [DW-1:0]    x_q, y_q, y_c;

	assign en       = !ov_q || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= lic_pkg::TOL_W'(1);
		end else if (cfg_wen) begin
			tol_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind;
			px_s1   <= p_x;
			py_s1   <= p_y;
			qx_s1   <= q_x;
			qy_s1   <= q_y;
			rx_s1   <= r_x;
			ry_s1   <= r_y;
			sx_s1   <= s_x;
			sy_s1   <= s_y;
		end
	end

	// line slopes
	always_comb begin
		dx1   = XW'(px_s1) - XW'(qx_s1);
		dx2   = XW'(rx_s1) - XW'(sx_s1);
		num1  = XW'(qy_s1) - XW'(py_s1);
		num2  = XW'(sy_s1) - XW'(ry_s1);
		ta_in = '0;
		ta_in.valid = valid_s1;
		ta_in.kind  = kind_s1;
		ta_in.v1    = lic_pkg::within_tol(dx1, tol_q);
		ta_in.v2    = lic_pkg::within_tol(dx2, tol_q);
		ta_in.px    = px_s1;
		ta_in.py    = py_s1;
		ta_in.rx    = rx_s1;
		ta_in.ry    = ry_s1;
	end

	lic_div u_div_a1 (.clk, .arst_n, .en, .tag_i(ta_in), .num(num1), .den(dx1),
		.tag_o(), .quo(a1q), .ovf(oa1));
	lic_div u_div_a2 (.clk, .arst_n, .en, .tag_i(ta_in), .num(num2), .den(dx2),
		.tag_o(ta), .quo(a2q), .ovf(oa2));

	// line offsets; a vertical line takes c = -x through the same unit
	always_comb begin
		tb_in     = ta;
		tb_in.a1  = ta.v1 ? lic_pkg::ONE_Q : a1q;
		tb_in.a2  = ta.v2 ? lic_pkg::ONE_Q : a2q;
		tb_in.ovf = (!ta.kind && !ta.v1 && oa1) || (!ta.v2 && oa2);
		c1_a      = tb_in.a1;
		c1_y      = ta.v1 ? '0 : ta.py;
		c2_a      = tb_in.a2;
		c2_y      = ta.v2 ? '0 : ta.ry;
	end

	lic_aff u_aff_c1 (.clk, .arst_n, .en, .tag_i(tb_in), .a(c1_a), .x(tb_in.px), .y(c1_y),
		.tag_o(), .res(c1r), .ovf(oc1));
	lic_aff u_aff_c2 (.clk, .arst_n, .en, .tag_i(tb_in), .a(c2_a), .x(tb_in.rx), .y(c2_y),
		.tag_o(tb), .res(c2r), .ovf(oc2));

	// classification, then perpendicular slope division
	always_comb begin
		tc_in      = tb;
		tc_in.c1   = c1r;
		tc_in.c2   = c2r;
		tc_in.ovf  = tb.ovf || (!tb.kind && oc1) || oc2;
		tc_in.par  = !tb.kind && ((tb.v1 && tb.v2) || (!tb.v1 && !tb.v2 &&
			lic_pkg::within_tol(XW'(tb.a1) - XW'(tb.a2), tol_q)));
		tc_in.rel  = !tc_in.par ? lic_pkg::REL_POINT :
			(lic_pkg::within_tol(XW'(c1r) - XW'(c2r), tol_q) ?
				lic_pkg::REL_COINCIDENT : lic_pkg::REL_PARALLEL);
		tc_in.gen0 = !tb.kind && !tc_in.par && !tb.v1 && !tb.v2;
		tc_in.gen1 = tb.kind && !tb.v2 && !lic_pkg::within_tol(XW'(tb.a2), tol_q);
		dnum_m     = XW'(lic_pkg::ONE_Q);
		dden_m     = XW'(tb.a2);
	end

	lic_div u_div_m (.clk, .arst_n, .en, .tag_i(tc_in), .num(dnum_m), .den(dden_m),
		.tag_o(tc), .quo(mq), .ovf(om));

	// perpendicular through the query point
	always_comb begin
		ns_m      = lic_pkg::neg_sat(mq);
		td_in     = tc;
		td_in.pa  = ns_m.v;
		td_in.ovf = tc.ovf || (tc.gen1 && (om || ns_m.o));
	end

	lic_aff u_aff_pc (.clk, .arst_n, .en, .tag_i(td_in), .a(td_in.pa), .x(td_in.px),
		.y(td_in.py), .tag_o(td), .res(pcr), .ovf(opc));

	// x of the meeting point
	always_comb begin
		te_in     = td;
		te_in.ovf = td.ovf || (td.gen1 && opc);
		if (!td.kind) begin
			dnum_x = XW'(td.c1) - XW'(td.c2);
			dden_x = XW'(td.a2) - XW'(td.a1);
		end else begin
			dnum_x = XW'(td.c2) - XW'(pcr);
			dden_x = XW'(td.pa) - XW'(td.a2);
		end
	end

	lic_div u_div_x (.clk, .arst_n, .en, .tag_i(te_in), .num(dnum_x), .den(dden_x),
		.tag_o(te), .quo(xq), .ovf(ox));

	// pick x, and the line that gives y
	always_comb begin
		nc1       = lic_pkg::neg_sat(te.c1);
		nc2       = lic_pkg::neg_sat(te.c2);
		tf_in     = te;
		tf_in.ovf = te.ovf || ((te.gen0 || te.gen1) && ox);
		tf_in.x   = '0;
		tf_in.y   = '0;
		tf_in.aff = 1'b0;
		ya        = te.a1;
		yc        = te.c1;
		if (!te.kind) begin
			if (te.par) begin
				tf_in.aff = 1'b0;
			end else if (te.v1) begin
				tf_in.x   = nc1.v;
				tf_in.ovf = tf_in.ovf || nc1.o;
				tf_in.aff = 1'b1;
				ya        = te.a2;
				yc        = te.c2;
			end else if (te.v2) begin
				tf_in.x   = nc2.v;
				tf_in.ovf = tf_in.ovf || nc2.o;
				tf_in.aff = 1'b1;
			end else begin
				tf_in.x   = xq;
				tf_in.aff = 1'b1;
			end
		end else begin
			if (te.v2) begin
				tf_in.x   = nc2.v;
				tf_in.y   = te.py;
				tf_in.ovf = tf_in.ovf || nc2.o;
			end else if (!te.gen1) begin
				// horizontal line
				tf_in.x   = te.px;
				tf_in.y   = nc2.v;
				tf_in.ovf = tf_in.ovf || nc2.o;
			end else begin
				tf_in.x   = xq;
				tf_in.aff = 1'b1;
				ya        = te.a2;
				yc        = te.c2;
			end
		end
	end

	lic_aff u_aff_y (.clk, .arst_n, .en, .tag_i(tf_in), .a(ya), .x(tf_in.x), .y(yc),
		.tag_o(tf), .res(yr), .ovf(oy));

	always_comb begin
		y_c   = tf.aff ? yr : tf.y;
		ovf_o = tf.ovf || (tf.aff && oy);
		rel_o = 1'b0;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= tf.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q   <= tf.x;
			y_q   <= y_c;
			rel_q <= tf.rel;
			ovf_q <= ovf_o || rel_o;
		end
	end

	assign out_valid = ov_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign relation  = rel_q;
	assign overflow  = ovf_q;

endmodule

// ===== src/lic_div.sv =====
// Pipelined restoring divider: saturated (num * 2^FRAC_BITS) / den, one quotient bit a stage.
module lic_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  lic_pkg::item_t                      tag_i,
	input  logic signed [lic_pkg::XW-1:0]       num,
	input  logic signed [lic_pkg::XW-1:0]       den,
	output lic_pkg::item_t                      tag_o,
	output logic signed [lic_pkg::DW-1:0]       quo,
	output logic                                ovf
);
	localparam int NS = lic_pkg::DIV_STEPS;
	localparam int XW = lic_pkg::XW;
	localparam int FB = lic_pkg::FRAC_BITS;
	localparam int NW = NS + FB;

	typedef struct packed {
		logic neg;
		logic zero;
		logic big;
		logic nz;
		logic sn;
	} dflag_t;

	logic [XW-1:0]  nmag, dmag;
	logic [NW-1:0]  nn;
	logic [FB-1:0]  rinit;
	logic           big;

	logic [XW-1:0]  rem_s [NS+1];
	logic [NS-1:0]  low_s [NS+1];
	logic [XW-1:0]  dv_s  [NS+1];
	logic [NS-1:0]  quo_s [NS+1];
	dflag_t         fl_s  [NS+1];
	lic_pkg::item_t tag_s [NS+2];

	logic signed [lic_pkg::DW-1:0] qres;
	logic                          qovf;

	always_comb begin
		nmag  = num[XW-1] ? XW'(-num) : XW'(num);
		dmag  = den[XW-1] ? XW'(-den) : XW'(den);
		nn    = {nmag, {FB{1'b0}}};
		rinit = nn[NW-1:NS];
		// quotient would need more than NS bits
		big   = XW'(rinit) >= dmag;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= XW'(rinit);
			low_s[0] <= nn[NS-1:0];
			dv_s[0]  <= dmag;
			quo_s[0] <= '0;
			fl_s[0]  <= '{neg: num[XW-1] ^ den[XW-1], zero: dmag == '0, big: big,
				nz: nmag != '0, sn: num[XW-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else if (en) begin
			tag_s[0] <= tag_i;
		end
	end

	for (genvar k = 1; k <= NS; k++) begin : g_step
		logic [XW:0] trial;
		logic        ge;

		assign trial = {rem_s[k-1], low_s[k-1][NS-1]};
		assign ge    = trial >= {1'b0, dv_s[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? XW'(trial - {1'b0, dv_s[k-1]}) : trial[XW-1:0];
				low_s[k] <= low_s[k-1] << 1;
				quo_s[k] <= {quo_s[k-1][NS-2:0], ge};
				dv_s[k]  <= dv_s[k-1];
				fl_s[k]  <= fl_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (en) begin
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	always_comb begin
		qres = '0;
		qovf = 1'b0;
		if (fl_s[NS].zero) begin
			if (fl_s[NS].nz) begin
				qres = fl_s[NS].sn ? lic_pkg::MIN_VAL : lic_pkg::MAX_VAL;
				qovf = 1'b1;
			end
		end else if (!fl_s[NS].neg) begin
			if (fl_s[NS].big || quo_s[NS] > NS'(lic_pkg::MAX_VAL)) begin
				qres = lic_pkg::MAX_VAL;
				qovf = 1'b1;
			end else begin
				qres = lic_pkg::DW'(quo_s[NS]);
			end
		end else begin
			// magnitude 2^(DW-1) still fits as the most negative value
			if (fl_s[NS].big || quo_s[NS] > {1'b0, lic_pkg::MIN_VAL}) begin
				qres = lic_pkg::MIN_VAL;
				qovf = 1'b1;
			end else begin
				qres = lic_pkg::DW'(-quo_s[NS]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= qres;
			ovf <= qovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[NS+1] <= '0;
		end else if (en) begin
			tag_s[NS+1] <= tag_s[NS];
		end
	end

	assign tag_o = tag_s[NS+1];

endmodule

// ===== src/lic_aff.sv =====
// Two-stage affine unit: saturated -(floor(a*x / 2^FRAC_BITS) + y).
module lic_aff (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  lic_pkg::item_t                tag_i,
	input  logic signed [lic_pkg::DW-1:0] a,
	input  logic signed [lic_pkg::DW-1:0] x,
	input  logic signed [lic_pkg::DW-1:0] y,
	output lic_pkg::item_t                tag_o,
	output logic signed [lic_pkg::DW-1:0] res,
	output logic                          ovf
);
	localparam int DW = lic_pkg::DW;
	localparam int PW = 2 * DW + 2;

	logic signed [2*DW-1:0] prod_s1;
	logic signed [DW-1:0]   y_s1;
	lic_pkg::item_t         tag_s1;
	logic signed [PW-1:0]   sum, nv;
	logic signed [DW-1:0]   r_c;
	logic                   o_c;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= a * x;
			y_s1    <= y;
		end
	end

	always_comb begin
		sum = (PW'(prod_s1) >>> lic_pkg::FRAC_BITS) + PW'(y_s1);
		nv  = -sum;
		if (nv[PW-1:DW-1] != {(PW-DW+1){nv[DW-1]}}) begin
			r_c = nv[PW-1] ? lic_pkg::MIN_VAL : lic_pkg::MAX_VAL;
			o_c = 1'b1;
		end else begin
			r_c = nv[DW-1:0];
			o_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= r_c;
			ovf <= o_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_o  <= '0;
		end else if (en) begin
			tag_s1 <= tag_i;
			tag_o  <= tag_s1;
		end
	end

endmodule

// ===== src/lic_chk.sv =====
// Port-level checks for the line geometry block, bound to the top level.
`include "line_intersect_closest_point_assert.svh"

module lic_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [lic_pkg::DW-1:0] out_x,
	input logic signed [lic_pkg::DW-1:0] out_y,
	input logic [1:0]                    relation,
	input logic                          overflow
);
	logic no_point;

	assign no_point = (relation == lic_pkg::REL_PARALLEL) ||
		(relation == lic_pkg::REL_COINCIDENT);

	// parallel or coincident transactions report the origin
	`LIC_ASSERT_NOW(a_nopoint_zero, out_valid && no_point, out_x == '0 && out_y == '0, "non-point result with nonzero coordinates")
	// the input side only stalls under output back-pressure
	`LIC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output back-pressure")
	`LIC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(relation) && $stable(overflow), "stalled result changed")

endmodule

bind line_intersect_closest_point lic_chk u_lic_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_x     (out_x),
	.out_y     (out_y),
	.relation  (relation),
	.overflow  (overflow)
);
